// ----- rtl/pli_pkg.sv -----
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants of the profile linear interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int DATA_W          = 32;
	localparam int SCALE_FRAC      = 24;
	localparam int MUL_W           = 34;
	localparam int PROD_W          = 2 * MUL_W;
	localparam int RAD_W           = 2 * DATA_W;
	localparam int ROOT_W          = DATA_W;
	localparam int DIV_W           = DATA_W + 1;

	localparam logic signed [DATA_W-1:0] SCALE_ONE = 32'sd16777216;

	typedef enum logic [1:0] {
		REQ_CLEAR = 2'd0,
		REQ_LOAD  = 2'd1,
		REQ_EVAL  = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FEW   = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	localparam logic [2:0] FM_VEC    = 3'd0;
	localparam logic [2:0] FM_VX     = 3'd1;
	localparam logic [2:0] FM_VY     = 3'd2;
	localparam logic [2:0] FM_VZ     = 3'd3;
	localparam logic [2:0] FM_SCALAR = 3'd4;
	localparam logic [2:0] FM_MAX    = 3'd7;

	localparam logic [1:0] CFG_FIELD_MODE = 2'd0;
	localparam logic [1:0] CFG_COORD_MODE = 2'd1;
	localparam logic [1:0] CFG_SCALE      = 2'd2;

	typedef struct packed {
		req_t                     req;
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic signed [DATA_W-1:0] z;
		logic signed [DATA_W-1:0] key;
		logic signed [DATA_W-1:0] va;
		logic signed [DATA_W-1:0] vr;
		logic signed [DATA_W-1:0] vc;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] key;
		logic signed [DATA_W-1:0] va;
		logic signed [DATA_W-1:0] vr;
		logic signed [DATA_W-1:0] vc;
	} row_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] ox;
		logic signed [DATA_W-1:0] oy;
		logic signed [DATA_W-1:0] oz;
		status_t                  status;
	} result_t;

	typedef struct packed {
		logic [2:0]               field_mode;
		logic                     coord_mode;
		logic signed [DATA_W-1:0] scale;
	} cfg_t;

endpackage

// ----- rtl/pli_if.sv -----
// ----------------------------------------------------------------------------
// pli_in_if / pli_out_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface pli_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic signed [31:0] coord_x;
	logic signed [31:0] coord_y;
	logic signed [31:0] coord_z;
	logic signed [31:0] entry_key;
	logic signed [31:0] value_axial;
	logic signed [31:0] value_radial;
	logic signed [31:0] value_circum;

	modport source(output valid, req_type, coord_x, coord_y, coord_z, entry_key,
		value_axial, value_radial, value_circum, input ready);
	modport sink(input valid, req_type, coord_x, coord_y, coord_z, entry_key,
		value_axial, value_radial, value_circum, output ready);
endinterface

interface pli_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic [1:0]         status;

	modport source(output valid, out_x, out_y, out_z, status, input ready);
	modport sink(input valid, out_x, out_y, out_z, status, output ready);
endinterface

// ----- rtl/pli_ram.sv -----
// ----------------------------------------------------------------------------
// pli_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
)(
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/pli_sqrt.sv -----
// ----------------------------------------------------------------------------
// pli_sqrt
// Integer square root, rounded down, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module pli_sqrt import pli_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  radicand,
	output logic              busy,
	output logic              done,
	output logic [ROOT_W-1:0] root
);
	localparam int REM_W = ROOT_W + 4;
	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              ge;

	assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rad_q  <= radicand;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= CNT_W'(ROOT_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rad_q  <= rad_q << 2;
				rem_q  <= ge ? rem_sh - trial : rem_sh;
				root_q <= {root_q[ROOT_W-2:0], ge};
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = root_q;
endmodule

// ----- rtl/pli_div.sv -----
// ----------------------------------------------------------------------------
// pli_div
// Restoring fraction divider: num * 2^(QW-1) / den for num <= den,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pli_div import pli_pkg::*; #(
	parameter int QW = FRAC_BITS_DEF + 1
)(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] num,
	input  logic [DIV_W-1:0] den,
	output logic             busy,
	output logic             done,
	output logic [QW-1:0]    quot
);
	localparam int CNT_W = $clog2(QW + 1);

	logic [DIV_W:0]   rem_q;
	logic [DIV_W-1:0] den_q;
	logic [QW-1:0]    quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             ge;
	logic [DIV_W:0]   rem_sub;

	assign ge      = rem_q >= {1'b0, den_q};
	assign rem_sub = ge ? rem_q - {1'b0, den_q} : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			den_q  <= '0;
			quot_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= {1'b0, num};
				den_q  <= den;
				quot_q <= '0;
				cnt_q  <= CNT_W'(QW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// remainder stays below den, so the shift never overflows
				rem_q  <= {rem_sub[DIV_W-1:0], 1'b0};
				quot_q <= {quot_q[QW-2:0], ge};
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quot_q;
endmodule

// ----- rtl/pli_front.sv -----
// ----------------------------------------------------------------------------
// pli_front
// Accepts request items, tags their kind and holds them in a two-entry queue
// ahead of the execution engine.
// ----------------------------------------------------------------------------
module pli_front import pli_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	pli_in_if.sink in_item,
	output logic  q_valid,
	output item_t q_item,
	input  logic  q_pop
);
	localparam int QD = 2;

	item_t      buf_q [QD];
	item_t      in_c;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;

	assign in_item.ready = fill_q != 2'(QD);
	assign push          = in_item.valid && in_item.ready;

	// payload fields that the request kind ignores are dropped here
	always_comb begin
		in_c     = '{req: req_t'(in_item.req_type), default: '0};
		case (req_t'(in_item.req_type))
			REQ_LOAD: begin
				in_c.key = in_item.entry_key;
				in_c.va  = in_item.value_axial;
				in_c.vr  = in_item.value_radial;
				in_c.vc  = in_item.value_circum;
			end
			REQ_EVAL: begin
				in_c.x = in_item.coord_x;
				in_c.y = in_item.coord_y;
				in_c.z = in_item.coord_z;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= in_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	assign q_valid = fill_q != '0;
	assign q_item  = buf_q[rd_ptr_q];
endmodule

// ----- rtl/pli_back.sv -----
// ----------------------------------------------------------------------------
// pli_back
// Execution engine: table maintenance, key search, interpolation, rotation
// and output scaling, sequenced over a shared multiplier, square root unit
// and divider.
// ----------------------------------------------------------------------------
module pli_back import pli_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
)(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  q_valid,
	input  item_t q_item,
	output logic  q_pop,
	pli_out_if.source out_item
);
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int TW    = FRAC_BITS + 1;
	localparam int CW    = FRAC_BITS + 2;
	localparam int ROW_W = $bits(row_t);
	localparam logic [CNT_W-1:0]        DEPTH_C = CNT_W'(TABLE_DEPTH);
	localparam logic signed [CW-1:0]    ONE_C   = CW'(1 << FRAC_BITS);
	localparam logic signed [PROD_W-1:0] P_MAX  = PROD_W'(32'sh7fffffff);
	localparam logic signed [PROD_W-1:0] P_MIN  = PROD_W'(32'sh80000000);
	localparam logic signed [DATA_W-1:0] KEY_MAX = 32'sh7fffffff;

	typedef enum logic [5:0] {
		B_IDLE, B_LCHK, B_LWAIT, B_LINS, B_SHCHK, B_SHWR,
		B_SQ1, B_SQ2, B_SQ3, B_SQRT, B_SCHK, B_SWAIT,
		B_RDLO, B_RDHI, B_DIVT, B_TWAIT,
		B_LA, B_LA2, B_LR2, B_LC2, B_DC, B_DS0, B_DS,
		B_ROT1, B_ROT2, B_ROT3, B_ROT4, B_ROT5,
		B_SC1, B_SC2, B_SC3, B_SC4
	} state_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > P_MAX) begin
			r = P_MAX[DATA_W-1:0];
		end else if (v < P_MIN) begin
			r = P_MIN[DATA_W-1:0];
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [MUL_W-1:0] sdiff(input logic signed [DATA_W-1:0] a,
			input logic signed [DATA_W-1:0] b);
		logic signed [MUL_W-1:0] r;
		r = MUL_W'(a) - MUL_W'(b);
		return r;
	endfunction

	function automatic logic [DIV_W-1:0] mag(input logic signed [DATA_W-1:0] a);
		logic signed [DIV_W-1:0] e;
		e = DIV_W'(a);
		return e[DIV_W-1] ? DIV_W'(-e) : DIV_W'(e);
	endfunction

	state_t                   state_q;
	item_t                    item_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         pos_q;
	logic [CNT_W-1:0]         shift_q;
	logic                     eq_q;
	logic [ROOT_W-1:0]        rad_q;
	logic signed [DATA_W-1:0] key_q;
	row_t                     row_lo_q;
	logic [TW-1:0]            t_q;
	logic signed [PROD_W-1:0] acc_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [DATA_W-1:0] va_q;
	logic signed [DATA_W-1:0] vr_q;
	logic signed [DATA_W-1:0] vc_q;
	logic signed [DATA_W-1:0] vx_q;
	logic signed [CW-1:0]     c_q;
	logic signed [CW-1:0]     s_q;
	logic signed [DATA_W-1:0] ox_q;
	logic signed [DATA_W-1:0] oy_q;
	result_t                  res_q;
	logic                     out_valid_q;

	logic signed [MUL_W-1:0]  mul_a;
	logic signed [MUL_W-1:0]  mul_b;
	logic                     ram_we;
	logic [IDX_W-1:0]         ram_waddr;
	logic [ROW_W-1:0]         ram_wdata;
	logic [IDX_W-1:0]         ram_raddr;
	logic [ROW_W-1:0]         ram_rdata;
	row_t                     rd_row;
	row_t                     new_row;
	logic                     sqrt_start;
	logic                     sqrt_busy;
	logic                     sqrt_done;
	logic [ROOT_W-1:0]        sqrt_root;
	logic                     div_start;
	logic [DIV_W-1:0]         div_num;
	logic [DIV_W-1:0]         div_den;
	logic                     div_busy;
	logic                     div_done;
	logic [TW-1:0]            div_quot;
	logic [CNT_W-1:0]         pos_m1;
	logic [CNT_W-1:0]         shift_m1;
	logic signed [DATA_W-1:0] lerp_c;
	logic signed [DATA_W-1:0] vy_c;
	logic signed [DATA_W-1:0] scaled_c;
	logic signed [CW-1:0]     quot_s;

	assign rd_row   = row_t'(ram_rdata);
	assign new_row  = '{key: item_q.key, va: item_q.va, vr: item_q.vr, vc: item_q.vc};
	assign pos_m1   = pos_q - 1'b1;
	assign shift_m1 = shift_q - 1'b1;
	assign q_pop    = (state_q == B_IDLE) && q_valid && !out_valid_q;
	assign lerp_c   = sat32(acc_q + (prod_q >>> FRAC_BITS));
	assign vy_c     = sat32((acc_q + prod_q) >>> FRAC_BITS);
	assign scaled_c = sat32(prod_q >>> SCALE_FRAC);
	assign quot_s   = CW'(div_quot);

	pli_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_DEPTH)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pli_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (RAD_W'(acc_q + prod_q)),
		.busy     (sqrt_busy),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	pli_div #(.QW(TW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_quot)
	);

	// datapath steering per sequencer step
	always_comb begin
		mul_a      = '0;
		mul_b      = '0;
		ram_we     = 1'b0;
		ram_waddr  = pos_q[IDX_W-1:0];
		ram_wdata  = new_row;
		ram_raddr  = pos_q[IDX_W-1:0];
		sqrt_start = 1'b0;
		div_start  = 1'b0;
		div_num    = DIV_W'(key_q) - DIV_W'(row_lo_q.key);
		div_den    = DIV_W'(rd_row.key) - DIV_W'(row_lo_q.key);
		case (state_q)
			B_LWAIT: begin
				if (rd_row.key == item_q.key) begin
					ram_we = 1'b1;
				end
			end
			B_SHCHK: begin
				if (shift_q == pos_q) begin
					ram_we = 1'b1;
				end else begin
					ram_raddr = shift_m1[IDX_W-1:0];
				end
			end
			B_SHWR: begin
				ram_we    = 1'b1;
				ram_waddr = shift_q[IDX_W-1:0];
				ram_wdata = ram_rdata;
			end
			B_SQ1: begin
				mul_a = MUL_W'(item_q.x);
				mul_b = MUL_W'(item_q.x);
			end
			B_SQ2: begin
				mul_a = MUL_W'(item_q.y);
				mul_b = MUL_W'(item_q.y);
			end
			B_SQ3:  sqrt_start = 1'b1;
			B_RDLO: ram_raddr = pos_m1[IDX_W-1:0];
			B_DIVT: div_start = 1'b1;
			B_LA: begin
				mul_a = sdiff(rd_row.va, row_lo_q.va);
				mul_b = MUL_W'(t_q);
			end
			B_LA2: begin
				mul_a = sdiff(rd_row.vr, row_lo_q.vr);
				mul_b = MUL_W'(t_q);
			end
			B_LR2: begin
				mul_a = sdiff(rd_row.vc, row_lo_q.vc);
				mul_b = MUL_W'(t_q);
			end
			B_LC2: begin
				div_start = rad_q != '0;
				div_num   = mag(item_q.x);
				div_den   = DIV_W'(rad_q);
			end
			B_DS0: begin
				div_start = 1'b1;
				div_num   = mag(item_q.y);
				div_den   = DIV_W'(rad_q);
			end
			B_ROT1: begin
				mul_a = MUL_W'(vr_q);
				mul_b = MUL_W'(c_q);
			end
			B_ROT2: begin
				mul_a = MUL_W'(vc_q);
				mul_b = MUL_W'(s_q);
			end
			B_ROT3: begin
				mul_a = MUL_W'(vr_q);
				mul_b = MUL_W'(s_q);
			end
			B_ROT4: begin
				mul_a = MUL_W'(vc_q);
				mul_b = MUL_W'(c_q);
			end
			B_SC1: begin
				mul_a = MUL_W'(ox_q);
				mul_b = MUL_W'(cfg.scale);
			end
			B_SC2: begin
				mul_a = MUL_W'(oy_q);
				mul_b = MUL_W'(cfg.scale);
			end
			B_SC3: begin
				mul_a = MUL_W'(res_q.oz);
				mul_b = MUL_W'(cfg.scale);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			item_q      <= '{req: REQ_CLEAR, default: '0};
			cnt_q       <= '0;
			pos_q       <= '0;
			shift_q     <= '0;
			eq_q        <= 1'b0;
			rad_q       <= '0;
			key_q       <= '0;
			row_lo_q    <= '0;
			t_q         <= '0;
			acc_q       <= '0;
			prod_q      <= '0;
			va_q        <= '0;
			vr_q        <= '0;
			vc_q        <= '0;
			vx_q        <= '0;
			c_q         <= '0;
			s_q         <= '0;
			ox_q        <= '0;
			oy_q        <= '0;
			res_q       <= '{ox: '0, oy: '0, oz: '0, status: ST_OK};
			out_valid_q <= 1'b0;
		end else begin
			prod_q <= mul_a * mul_b;
			if (out_valid_q && out_item.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (q_pop) begin
						item_q <= q_item;
						pos_q  <= '0;
						case (q_item.req)
							REQ_LOAD: state_q <= B_LCHK;
							REQ_EVAL: state_q <= B_SQ1;
							REQ_CLEAR: begin
								cnt_q       <= '0;
								res_q       <= '{ox: '0, oy: '0, oz: '0, status: ST_OK};
								out_valid_q <= 1'b1;
							end
							default: begin
								res_q       <= '{ox: '0, oy: '0, oz: '0, status: ST_OK};
								out_valid_q <= 1'b1;
							end
						endcase
					end
				end
				// load: find the first key not below the new one
				B_LCHK: begin
					state_q <= (pos_q == cnt_q) ? B_LINS : B_LWAIT;
				end
				B_LWAIT: begin
					if (rd_row.key < item_q.key) begin
						pos_q   <= pos_q + 1'b1;
						state_q <= B_LCHK;
					end else if (rd_row.key == item_q.key) begin
						res_q       <= '{ox: '0, oy: '0, oz: '0, status: ST_OK};
						out_valid_q <= 1'b1;
						state_q     <= B_IDLE;
					end else begin
						state_q <= B_LINS;
					end
				end
				B_LINS: begin
					if (cnt_q == DEPTH_C) begin
						res_q       <= '{ox: '0, oy: '0, oz: '0, status: ST_FULL};
						out_valid_q <= 1'b1;
						state_q     <= B_IDLE;
					end else begin
						shift_q <= cnt_q;
						state_q <= B_SHCHK;
					end
				end
				// open a slot by moving rows up one at a time from the top
				B_SHCHK: begin
					if (shift_q == pos_q) begin
						cnt_q       <= cnt_q + 1'b1;
						res_q       <= '{ox: '0, oy: '0, oz: '0, status: ST_OK};
						out_valid_q <= 1'b1;
						state_q     <= B_IDLE;
					end else begin
						state_q <= B_SHWR;
					end
				end
				B_SHWR: begin
					shift_q <= shift_m1;
					state_q <= B_SHCHK;
				end
				B_SQ1: state_q <= B_SQ2;
				B_SQ2: begin
					acc_q   <= prod_q;
					state_q <= B_SQ3;
				end
				B_SQ3: state_q <= B_SQRT;
				B_SQRT: begin
					if (sqrt_done) begin
						rad_q <= sqrt_root;
						if (cfg.coord_mode) begin
							key_q <= item_q.z;
						end else begin
							key_q <= sqrt_root[ROOT_W-1] ? KEY_MAX : $signed(sqrt_root);
						end
						eq_q  <= 1'b0;
						pos_q <= '0;
						if (cnt_q < CNT_W'(2)) begin
							res_q       <= '{ox: '0, oy: '0, oz: '0, status: ST_FEW};
							out_valid_q <= 1'b1;
							state_q     <= B_IDLE;
						end else begin
							state_q <= B_SCHK;
						end
					end
				end
				// evaluate: find the first key above the lookup key
				B_SCHK: begin
					if (pos_q == cnt_q) begin
						if (eq_q) begin
							pos_q   <= cnt_q - 1'b1;
							state_q <= B_RDLO;
						end else begin
							res_q       <= '{ox: '0, oy: '0, oz: '0, status: ST_RANGE};
							out_valid_q <= 1'b1;
							state_q     <= B_IDLE;
						end
					end else begin
						state_q <= B_SWAIT;
					end
				end
				B_SWAIT: begin
					if (rd_row.key <= key_q) begin
						eq_q    <= rd_row.key == key_q;
						pos_q   <= pos_q + 1'b1;
						state_q <= B_SCHK;
					end else if (pos_q == '0) begin
						res_q       <= '{ox: '0, oy: '0, oz: '0, status: ST_RANGE};
						out_valid_q <= 1'b1;
						state_q     <= B_IDLE;
					end else begin
						state_q <= B_RDLO;
					end
				end
				B_RDLO: state_q <= B_RDHI;
				B_RDHI: begin
					row_lo_q <= rd_row;
					state_q  <= B_DIVT;
				end
				B_DIVT: state_q <= B_TWAIT;
				B_TWAIT: begin
					if (div_done) begin
						t_q     <= div_quot;
						state_q <= B_LA;
					end
				end
				// read data still holds the upper row through the lerp steps
				B_LA: begin
					acc_q   <= PROD_W'(row_lo_q.va);
					state_q <= B_LA2;
				end
				B_LA2: begin
					va_q  <= lerp_c;
					acc_q <= PROD_W'(row_lo_q.vr);
					if (cfg.field_mode inside {[FM_SCALAR:FM_MAX]}) begin
						ox_q    <= lerp_c;
						oy_q    <= '0;
						res_q   <= '{ox: '0, oy: '0, oz: '0, status: ST_OK};
						state_q <= B_SC1;
					end else begin
						state_q <= B_LR2;
					end
				end
				B_LR2: begin
					vr_q    <= lerp_c;
					acc_q   <= PROD_W'(row_lo_q.vc);
					state_q <= B_LC2;
				end
				B_LC2: begin
					vc_q <= lerp_c;
					if (rad_q == '0) begin
						c_q     <= ONE_C;
						s_q     <= '0;
						state_q <= B_ROT1;
					end else begin
						state_q <= B_DC;
					end
				end
				B_DC: begin
					if (div_done) begin
						c_q     <= item_q.x[DATA_W-1] ? -quot_s : quot_s;
						state_q <= B_DS0;
					end
				end
				B_DS0: state_q <= B_DS;
				B_DS: begin
					if (div_done) begin
						s_q     <= item_q.y[DATA_W-1] ? -quot_s : quot_s;
						state_q <= B_ROT1;
					end
				end
				B_ROT1: state_q <= B_ROT2;
				B_ROT2: begin
					acc_q   <= prod_q;
					state_q <= B_ROT3;
				end
				B_ROT3: begin
					vx_q    <= sat32((acc_q - prod_q) >>> FRAC_BITS);
					state_q <= B_ROT4;
				end
				B_ROT4: begin
					acc_q   <= prod_q;
					state_q <= B_ROT5;
				end
				B_ROT5: begin
					oy_q  <= (cfg.field_mode == FM_VEC) ? vy_c : '0;
					res_q <= '{ox: '0, oy: '0,
						oz: (cfg.field_mode == FM_VEC) ? va_q : '0, status: ST_OK};
					case (cfg.field_mode)
						FM_VEC, FM_VX: ox_q <= vx_q;
						FM_VY:         ox_q <= vy_c;
						default:       ox_q <= va_q;
					endcase
					state_q <= B_SC1;
				end
				B_SC1: state_q <= B_SC2;
				B_SC2: begin
					ox_q    <= scaled_c;
					state_q <= B_SC3;
				end
				B_SC3: begin
					oy_q    <= scaled_c;
					state_q <= B_SC4;
				end
				B_SC4: begin
					res_q       <= '{ox: ox_q, oy: oy_q, oz: scaled_c, status: ST_OK};
					out_valid_q <= 1'b1;
					state_q     <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign out_item.valid  = out_valid_q;
	assign out_item.out_x  = res_q.ox;
	assign out_item.out_y  = res_q.oy;
	assign out_item.out_z  = res_q.oz;
	assign out_item.status = res_q.status;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("point count above table depth");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.status != ST_OK |->
		res_q.ox == '0 && res_q.oy == '0 && res_q.oz == '0)
		else $error("error status with nonzero outputs");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_sqrt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_start |-> !sqrt_busy)
		else $error("square root started while busy");

	a_pop_free: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q != B_IDLE || out_valid_q)
		else $error("item taken without result or work");
endmodule

// ----- rtl/profile_linear_interpolator.sv -----
// ----------------------------------------------------------------------------
// profile_linear_interpolator
// Sorted profile table with clear, load and evaluate requests; linear
// interpolation, cylindrical to Cartesian rotation and output scaling.
// ----------------------------------------------------------------------------
// One result item per request item. A load scans the table one row at a time
// up to the insert point, then moves each higher row up one at a time. An
// evaluate runs the square root unit, which yields one root bit per cycle,
// and the divider, one quotient bit per cycle (run once for the ratio and,
// unless the field mode is scalar or the radius is zero, twice for the
// angle); the linear key search reads the table memory through its single
// read port, and all products share one registered multiplier. The engine
// takes the next item only once the last result has gone; items are queued
// two deep ahead of the engine, and a finished result waits in an output
// register.
module profile_linear_interpolator import pli_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
)(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	pli_in_if.sink      in_item,
	pli_out_if.source   out_item
);
	cfg_t  cfg_q;
	logic  q_valid;
	item_t q_item;
	logic  q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{field_mode: FM_VEC, coord_mode: 1'b0, scale: SCALE_ONE};
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIELD_MODE: cfg_q.field_mode <= cfg_wdata[2:0];
				CFG_COORD_MODE: cfg_q.coord_mode <= cfg_wdata[0];
				CFG_SCALE:      cfg_q.scale      <= $signed(cfg_wdata);
				default: begin
				end
			endcase
		end
	end

	pli_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_item (in_item),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	pli_back #(.TABLE_DEPTH(TABLE_DEPTH), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.out_item (out_item)
	);
endmodule
